### rtl/cspv_pkg.sv
// ----------------------------------------------------------------------------
// cspv_pkg
// Shared widths, types and constant trigonometric tables of the cube-sphere
// face vertex unit.
// ----------------------------------------------------------------------------
package cspv_pkg;

  localparam int unsigned QW         = 31;   // Q30 magnitude, holds 1.0 exactly
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned LVL_W      = 3;
  localparam int unsigned TAB_LOG    = 7;
  localparam int unsigned TAB_TOP    = 128;
  localparam int unsigned SQ_W       = 62;
  localparam int unsigned NORM_W     = 32;
  localparam int unsigned SQRT_STEPS = 31;

  localparam logic [63:0] Q_ONE   = 64'd1 << 30;
  localparam logic [63:0] PI4_Q30 = 64'd843314857;

  typedef logic [QW-1:0] q30_t;
  typedef q30_t trig_tab_t [0:TAB_TOP];

  // Direction magnitudes with the signs of the y and z components.
  typedef struct packed {
    q30_t vx;
    q30_t vy;
    q30_t vz;
    logic neg_y;
    logic neg_z;
  } vec_t;

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] sin_q(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] r;
    t2 = qmul(t, t);
    r  = Q_ONE;
    r  = Q_ONE - qmul(t2, r) / 110;
    r  = Q_ONE - qmul(t2, r) / 72;
    r  = Q_ONE - qmul(t2, r) / 42;
    r  = Q_ONE - qmul(t2, r) / 20;
    r  = Q_ONE - qmul(t2, r) / 6;
    return qmul(t, r);
  endfunction

  function automatic logic [63:0] cos_q(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] r;
    t2 = qmul(t, t);
    r  = Q_ONE;
    r  = Q_ONE - qmul(t2, r) / 132;
    r  = Q_ONE - qmul(t2, r) / 90;
    r  = Q_ONE - qmul(t2, r) / 56;
    r  = Q_ONE - qmul(t2, r) / 30;
    r  = Q_ONE - qmul(t2, r) / 12;
    r  = Q_ONE - qmul(t2, r) / 2;
    return r;
  endfunction

  // Angle k of the finest grid is 45 degrees times k/128, in Q30 radians.
  function automatic trig_tab_t build_trig_tab(logic want_cos);
    trig_tab_t   tab;
    logic [63:0] t;
    for (int k = 0; k <= TAB_TOP; k++) begin
      t      = (PI4_Q30 * 64'(k)) >> TAB_LOG;
      tab[k] = want_cos ? QW'(cos_q(t)) : QW'(sin_q(t));
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_trig_tab(1'b1);

endpackage

### rtl/cspv_isqrt.sv
// ----------------------------------------------------------------------------
// cspv_isqrt
// Pipelined integer square root, one result bit per stage, with the vector
// magnitudes carried alongside.
// ----------------------------------------------------------------------------
module cspv_isqrt
  import cspv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   sq_i,
  input  vec_t              vec_i,
  output logic              valid_o,
  output logic [NORM_W-1:0] norm_o,
  output vec_t              vec_o
);

  logic [63:0] rem_q [SQRT_STEPS];
  logic [63:0] res_q [SQRT_STEPS];
  vec_t        vec_q [SQRT_STEPS];
  logic        vld_q [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic [63:0] rem_in, res_in, bit_v, trial;
    vec_t        vec_in;
    logic        vld_in;

    if (g == 0) begin : g_first
      assign rem_in = 64'(sq_i);
      assign res_in = '0;
      assign vec_in = vec_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign res_in = res_q[g-1];
      assign vec_in = vec_q[g-1];
      assign vld_in = vld_q[g-1];
    end

    assign bit_v = 64'd1 << (2 * (SQRT_STEPS - 1 - g));
    assign trial = res_in + bit_v;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[g] <= rem_in - trial;
          res_q[g] <= (res_in >> 1) + bit_v;
        end else begin
          rem_q[g] <= rem_in;
          res_q[g] <= res_in >> 1;
        end
        vec_q[g] <= vec_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign norm_o  = res_q[SQRT_STEPS-1][NORM_W-1:0];
  assign vec_o   = vec_q[SQRT_STEPS-1];

endmodule

### rtl/cspv_div.sv
// ----------------------------------------------------------------------------
// cspv_div
// Three-lane pipelined restoring divider forming the rounded quotient
// mag * 2^(B-1) / norm, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cspv_div
  import cspv_pkg::*;
#(
  parameter int CompBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [NORM_W-1:0]              norm_i,
  input  vec_t                           vec_i,
  output logic                           valid_o,
  output logic [2:0][CompBits-1:0]       quot_o,
  output logic                           norm_zero_o,
  output logic                           neg_y_o,
  output logic                           neg_z_o
);

  localparam int NumW = QW + CompBits;
  localparam int RemW = NORM_W + 1;

  logic [RemW-1:0]     rem_q  [CompBits+1][3];
  logic [CompBits-1:0] low_q  [CompBits+1][3];
  logic [CompBits-1:0] quot_q [CompBits+1][3];
  logic [NORM_W-1:0]   norm_q [CompBits+1];
  logic                nz_q   [CompBits+1];
  logic                ny_q   [CompBits+1];
  logic                nzs_q  [CompBits+1];
  logic                vld_q  [CompBits+1];

  q30_t mag_in [3];
  assign mag_in[0] = vec_i.vx;
  assign mag_in[1] = vec_i.vy;
  assign mag_in[2] = vec_i.vz;

  // Stage 0 forms the numerator with the half-divisor rounding term.
  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic [NumW-1:0] num;
    assign num = NumW'({mag_in[l], {(CompBits-1){1'b0}}}) + NumW'(norm_i >> 1);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l]  <= RemW'(num[NumW-1:CompBits]);
        low_q[0][l]  <= num[CompBits-1:0];
        quot_q[0][l] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q[0] <= norm_i;
      nz_q[0]   <= (norm_i == '0);
      ny_q[0]   <= vec_i.neg_y;
      nzs_q[0]  <= vec_i.neg_z;
    end
  end

  for (genvar g = 1; g <= CompBits; g++) begin : g_step
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RemW-1:0] trial;
      assign trial = {rem_q[g-1][l][RemW-2:0], low_q[g-1][l][CompBits-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (trial >= RemW'(norm_q[g-1])) begin
            rem_q[g][l]  <= trial - RemW'(norm_q[g-1]);
            quot_q[g][l] <= {quot_q[g-1][l][CompBits-2:0], 1'b1};
          end else begin
            rem_q[g][l]  <= trial;
            quot_q[g][l] <= {quot_q[g-1][l][CompBits-2:0], 1'b0};
          end
          low_q[g][l] <= low_q[g-1][l] << 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        norm_q[g] <= norm_q[g-1];
        nz_q[g]   <= nz_q[g-1];
        ny_q[g]   <= ny_q[g-1];
        nzs_q[g]  <= nzs_q[g-1];
      end
    end
  end

  for (genvar g = 0; g <= CompBits; g++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= (g == 0) ? valid_i : vld_q[(g == 0) ? 0 : g-1];
      end
    end
  end

  assign valid_o     = vld_q[CompBits];
  assign quot_o[0]   = quot_q[CompBits][0];
  assign quot_o[1]   = quot_q[CompBits][1];
  assign quot_o[2]   = quot_q[CompBits][2];
  assign norm_zero_o = nz_q[CompBits];
  assign neg_y_o     = ny_q[CompBits];
  assign neg_z_o     = nzs_q[CompBits];

endmodule

### rtl/cube_sphere_face_vertex_unit.sv
// ----------------------------------------------------------------------------
// cube_sphere_face_vertex_unit
// Turns a grid position on the +X cube face into a unit-sphere vertex.
// ----------------------------------------------------------------------------
// Pipeline: five front stages, 31 square-root stages, one divider set-up
// stage, one divider stage per output bit and the output register.
// Throughput: one request per cycle while the output is not stalled;
// every stage holds one request.
// Reset clears all valid bits and loads a subdivision level of 5.
// ----------------------------------------------------------------------------
module cube_sphere_face_vertex_unit
  import cspv_pkg::*;
#(
  parameter int MAX_SUBDIVISION = 7,
  parameter int COMPONENT_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [LVL_W-1:0]     cfg_wr_data_i,   // subdivision_level
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,  // row_index [7:0], column_index [15:8]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // unit_x, unit_y, unit_z from the lowest bits up, zero padded to bytes
  output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int OutW = ((3 * COMPONENT_BITS + 7) / 8) * 8;
  localparam int B    = COMPONENT_BITS;
  // The register cannot exceed 7, so only a smaller cap has any effect.
  localparam logic [LVL_W-1:0] LvlCap =
    (MAX_SUBDIVISION < 7) ? LVL_W'(MAX_SUBDIVISION) : LVL_W'(TAB_LOG);

  // The whole pipeline advances together whenever the output register is
  // free or being emptied. The first stage may also fill while it is empty,
  // so a new request is taken even while a finished result waits.
  logic en;
  logic out_v_q;
  logic a_v_q;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en || !a_v_q;

  logic [LVL_W-1:0] subdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= LVL_W'(5);
    end else if (cfg_wr_en_i) begin
      subdiv_q <= cfg_wr_data_i;
    end
  end

  // Stage A: clamp both indices and map them onto the finest angle grid of
  // 128 steps per 45 degrees. Latitude runs down from +45 degrees, so its
  // sign flips past the middle row; longitude starts negative.
  logic [LVL_W-1:0] lvl;
  logic [8:0]       n9;
  logic [8:0]       row9, col9;
  logic [9:0]       n10, two_i, two_j, m1, m2;
  logic             neg1, neg2;
  logic [IDX_W-1:0] k1, k2;

  always_comb begin
    lvl   = (subdiv_q > LvlCap) ? LvlCap : subdiv_q;
    n9    = 9'd1 << lvl;
    n10   = {1'b0, n9};
    row9  = ({1'b0, s_axis_tdata_i[7:0]} > n9) ? n9 : {1'b0, s_axis_tdata_i[7:0]};
    col9  = ({1'b0, s_axis_tdata_i[15:8]} > n9) ? n9 : {1'b0, s_axis_tdata_i[15:8]};
    two_i = {row9, 1'b0};
    two_j = {col9, 1'b0};
    neg2  = two_i > n10;
    m2    = neg2 ? (two_i - n10) : (n10 - two_i);
    neg1  = n10 > two_j;
    m1    = neg1 ? (n10 - two_j) : (two_j - n10);
    k1    = IDX_W'(m1 << (LVL_W'(TAB_LOG) - lvl));
    k2    = IDX_W'(m2 << (LVL_W'(TAB_LOG) - lvl));
  end

  logic [IDX_W-1:0] a_k1_q, a_k2_q;
  logic             a_ny_q, a_nz_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      a_k1_q <= k1;
      a_k2_q <= k2;
      a_ny_q <= neg2;
      a_nz_q <= !neg1 && (m1 != '0);
    end
  end

  // Stage B: sine and cosine of both angles from the constant tables.
  q30_t b_s1_q, b_c1_q, b_s2_q, b_c2_q;
  logic b_ny_q, b_nz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_s1_q <= SIN_TAB[a_k1_q];
      b_c1_q <= COS_TAB[a_k1_q];
      b_s2_q <= SIN_TAB[a_k2_q];
      b_c2_q <= COS_TAB[a_k2_q];
      b_ny_q <= a_ny_q;
      b_nz_q <= a_nz_q;
    end
  end

  // Stage C: the cross product of the two plane normals, Q30 truncated.
  logic [2*QW-1:0] px, py, pz;
  assign px = (2*QW)'(b_c1_q) * (2*QW)'(b_c2_q);
  assign py = (2*QW)'(b_c1_q) * (2*QW)'(b_s2_q);
  assign pz = (2*QW)'(b_s1_q) * (2*QW)'(b_c2_q);

  vec_t c_vec_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_vec_q.vx    <= px[QW+29:30];
      c_vec_q.vy    <= py[QW+29:30];
      c_vec_q.vz    <= pz[QW+29:30];
      c_vec_q.neg_y <= b_ny_q;
      c_vec_q.neg_z <= b_nz_q;
    end
  end

  // Stage D: squares of the three components.
  logic [SQ_W-1:0] d_sx_q, d_sy_q, d_sz_q;
  vec_t            d_vec_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_sx_q  <= SQ_W'(c_vec_q.vx) * SQ_W'(c_vec_q.vx);
      d_sy_q  <= SQ_W'(c_vec_q.vy) * SQ_W'(c_vec_q.vy);
      d_sz_q  <= SQ_W'(c_vec_q.vz) * SQ_W'(c_vec_q.vz);
      d_vec_q <= c_vec_q;
    end
  end

  // Stage E: sum of squares. Each square is at most 2^60, so the sum fits.
  logic [SQ_W-1:0] e_sum_q;
  vec_t            e_vec_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_sum_q <= d_sx_q + d_sy_q + d_sz_q;
      e_vec_q <= d_vec_q;
    end
  end

  logic b_v_q, c_v_q, d_v_q, e_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        a_v_q <= s_axis_tvalid_i;
      end
      if (en) begin
        b_v_q <= a_v_q;
        c_v_q <= b_v_q;
        d_v_q <= c_v_q;
        e_v_q <= d_v_q;
      end
    end
  end

  // Norm of the direction, then the three normalising divisions.
  logic              sq_v;
  logic [NORM_W-1:0] sq_norm;
  vec_t              sq_vec;

  cspv_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_v_q),
    .sq_i    (e_sum_q),
    .vec_i   (e_vec_q),
    .valid_o (sq_v),
    .norm_o  (sq_norm),
    .vec_o   (sq_vec)
  );

  logic              dv_v;
  logic [2:0][B-1:0] dv_quot;
  logic              dv_nzero, dv_ny, dv_nz;

  cspv_div #(
    .CompBits (B)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (sq_v),
    .norm_i      (sq_norm),
    .vec_i       (sq_vec),
    .valid_o     (dv_v),
    .quot_o      (dv_quot),
    .norm_zero_o (dv_nzero),
    .neg_y_o     (dv_ny),
    .neg_z_o     (dv_nz)
  );

  // Output stage: a quotient of exactly one saturates to the largest
  // positive code, then the sign is applied. A zero norm gives zeros.
  localparam logic [B-1:0] MaxPos = {1'b0, {(B-1){1'b1}}};
  logic [B-1:0] sat_x, sat_y, sat_z;
  logic [B-1:0] out_x_q, out_y_q, out_z_q;

  assign sat_x = dv_quot[0][B-1] ? MaxPos : dv_quot[0];
  assign sat_y = dv_quot[1][B-1] ? MaxPos : dv_quot[1];
  assign sat_z = dv_quot[2][B-1] ? MaxPos : dv_quot[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= dv_nzero ? '0 : sat_x;
      out_y_q <= dv_nzero ? '0 : (dv_ny ? (~sat_y + 1'b1) : sat_y);
      out_z_q <= dv_nzero ? '0 : (dv_nz ? (~sat_z + 1'b1) : sat_z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OutW'({out_z_q, out_y_q, out_x_q});

  // The x component is cos a1 cos a2, at least one half, so it is positive.
  a_x_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!out_x_q[B-1] && (out_x_q != '0)))
    else $error("x component not positive");

  // An empty first stage always takes a request.
  a_first_stage_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_v_q |-> s_axis_tready_o)
    else $error("first stage empty but request refused");

  // A stalled pipeline keeps its occupied first stage.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && a_v_q) |=> a_v_q)
    else $error("request lost during stall");

  // A stall freezes the divider output feeding the result register.
  a_div_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && dv_v) |=> dv_v)
    else $error("divider result lost during stall");

endmodule
